FILE: rtl/text_console_char_writer_defines.svh
// Assertion macros shared by the text console writer checkers.
// Depends on nothing; included by the checker file.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Consequent must hold in the clock after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer check failed");

// Consequent must hold in the same clock as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer check failed");

`endif

FILE: rtl/tcw_pkg.sv
// Shared types and constants of the text console character writer.
// Depends on nothing; used by the interfaces and all modules.
package tcw_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int RROW_W     = 5;
    localparam int RCOL_W     = 7;
    localparam int CELL_W     = 16;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 6;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR   = 2'd2;

    localparam logic [COL_W-1:0]  WIDTH_RESET  = 8'd80;
    localparam logic [ROW_W-1:0]  HEIGHT_RESET = 6'd25;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    typedef struct packed {
        logic [COL_W-1:0]  cols;
        logic [ROW_W-1:0]  rows;
        logic [ATTR_W-1:0] attr;
    } t_cfg;

endpackage

FILE: rtl/tcw_if.sv
// Valid/ready channels of the text console writer: command words in, result words out.
// Depends on tcw_pkg for the field widths.
interface tcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CMD_W-1:0]     command;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::RROW_W-1:0]    read_row;
    logic [tcw_pkg::RCOL_W-1:0]    read_col;

    modport source (output valid, command, char_code, read_row, read_col, input ready);
    modport sink (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CELL_W-1:0]    cell_value;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;

    modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
    modport sink (input valid, cell_value, cursor_col, cursor_row, output ready);
endinterface

FILE: rtl/tcw_screen_ram.sv
// Screen cell memory: one write port and one read port with registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tcw_ctrl.sv
// Command sequencer: cursor, wrap and scroll, memory walks, output register.
// Depends on tcw_pkg, tcw_if and the screen memory ports.
module tcw_ctrl #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcw_pkg::t_cfg              i_cfg,
    tcw_in_if.sink                     i_in,
    tcw_out_if.source                  o_out,
    output logic                       o_ram_we,
    output logic [AW-1:0]              o_ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0] o_ram_wdata,
    output logic [AW-1:0]              o_ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_ram_rdata
);

    localparam int IW = AW + 1;
    localparam int PW = tcw_pkg::ROW_W + tcw_pkg::COL_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_MOVE, S_FILL, S_CHAR, S_RDWAIT, S_CLEAR, S_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [IW-1:0]                 r_keep, n_keep;
    logic [IW-1:0]                 r_total, n_total;
    logic [tcw_pkg::CMD_W-1:0]     r_cmd, n_cmd;
    logic [tcw_pkg::CHAR_W-1:0]    r_char, n_char;
    logic [tcw_pkg::RROW_W-1:0]    r_row, n_row;
    logic [tcw_pkg::RCOL_W-1:0]    r_col, n_col;
    logic [tcw_pkg::COL_W-1:0]     r_cx, n_cx;
    logic [tcw_pkg::ROW_W-1:0]     r_cy, n_cy;
    logic [tcw_pkg::CELL_W-1:0]    r_cell, n_cell;
    logic                          r_out_valid, n_out_valid;
    logic [tcw_pkg::CELL_W-1:0]    r_out_cell, n_out_cell;
    logic [tcw_pkg::COL_W-1:0]     r_out_col, n_out_col;
    logic [tcw_pkg::ROW_W-1:0]     r_out_row, n_out_row;

    logic                          wrap;
    logic [tcw_pkg::COL_W-1:0]     cx_w;
    logic [tcw_pkg::ROW_W-1:0]     cy_w;
    logic [tcw_pkg::COL_W-1:0]     bs_x;
    logic [PW-1:0]                 cur_base;
    logic [PW-1:0]                 rd_addr;

    always_comb begin
        wrap     = (r_cx >= i_cfg.cols);
        cx_w     = wrap ? '0 : r_cx;
        cy_w     = wrap ? r_cy + 1'b1 : r_cy;
        bs_x     = (r_cx != '0) ? r_cx - 1'b1 : r_cx;
        cur_base = PW'(r_cy) * PW'(i_cfg.cols);
        rd_addr  = PW'(r_row) * PW'(i_cfg.cols) + PW'(r_col);

        n_state     = r_state;
        n_idx       = r_idx;
        n_keep      = r_keep;
        n_total     = r_total;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_row       = r_row;
        n_col       = r_col;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_cell  = r_out_cell;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx[AW-1:0];
        o_ram_wdata = '0;
        o_ram_raddr = r_idx[AW-1:0] + AW'(i_cfg.cols);

        unique case (r_state)
            S_INIT: begin
                o_ram_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == IW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.command;
                    n_char  = i_in.char_code;
                    n_row   = i_in.read_row;
                    n_col   = i_in.read_col;
                    n_cell  = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_keep  = IW'(PW'(i_cfg.cols) * PW'(i_cfg.rows - 1'b1));
                n_total = IW'(PW'(i_cfg.cols) * PW'(i_cfg.rows));
                n_idx   = '0;
                n_state = S_DONE;
                case (r_cmd)
                    tcw_pkg::CMD_PUT: begin
                        if (r_char != tcw_pkg::CH_NUL) begin
                            n_cx = cx_w;
                            n_cy = cy_w;
                            if (cy_w >= i_cfg.rows) begin
                                n_state = S_MOVE;
                            end else begin
                                n_state = S_CHAR;
                            end
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        o_ram_raddr = AW'(rd_addr);
                        if (tcw_pkg::ROW_W'(r_row) < i_cfg.rows
                                && tcw_pkg::COL_W'(r_col) < i_cfg.cols) begin
                            n_state = S_RDWAIT;
                        end
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MOVE: begin
                o_ram_waddr = r_idx[AW-1:0] - 1'b1;
                o_ram_wdata = i_ram_rdata;
                o_ram_we    = (r_idx != '0);
                if (r_idx == r_keep) begin
                    n_state = S_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FILL: begin
                o_ram_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == r_total - 1'b1) begin
                    n_cy    = i_cfg.rows - 1'b1;
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                n_state = S_DONE;
                case (r_char)
                    tcw_pkg::CH_LF: begin
                        n_cy = r_cy + 1'b1;
                        n_cx = '0;
                    end
                    tcw_pkg::CH_CR: begin
                        n_cx = '0;
                    end
                    tcw_pkg::CH_BS: begin
                        n_cx        = bs_x;
                        o_ram_we    = 1'b1;
                        o_ram_waddr = AW'(cur_base + PW'(bs_x));
                        o_ram_wdata = {i_cfg.attr, tcw_pkg::CH_NUL};
                    end
                    default: begin
                        n_cx        = r_cx + 1'b1;
                        o_ram_we    = 1'b1;
                        o_ram_waddr = AW'(cur_base + PW'(r_cx));
                        o_ram_wdata = {i_cfg.attr, r_char};
                    end
                endcase
            end
            S_RDWAIT: begin
                n_cell  = i_ram_rdata;
                n_state = S_DONE;
            end
            S_CLEAR: begin
                o_ram_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == r_total - 1'b1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_cell;
                    n_out_col   = r_cx;
                    n_out_row   = r_cy;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_out_valid <= n_out_valid;
        end
        r_keep     <= n_keep;
        r_total    <= n_total;
        r_cmd      <= n_cmd;
        r_char     <= n_char;
        r_row      <= n_row;
        r_col      <= n_col;
        r_cell     <= n_cell;
        r_out_cell <= n_out_cell;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.cell_value = r_out_cell;
    assign o_out.cursor_col = r_out_col;
    assign o_out.cursor_row = r_out_row;

endmodule

FILE: rtl/text_console_char_writer.sv
// Text console character writer. Each command word (put character, read cell, clear
// screen) yields one result word with the cell read (zero for other commands) and the
// cursor after the command. The screen lives in one synchronous memory of
// MAX_COLS*MAX_ROWS cells, stored row by row at the width in use. Each command word goes
// through the sequencer's decode and done states, with character, read-wait, scroll or
// clear states between them as it needs, and a read uses the registered memory read data.
// A put that scrolls moves one memory cell per cycle; a clear zeroes the screen in use.
// After reset a clearing pass writes zero to all MAX_COLS*MAX_ROWS cells, one per
// cycle, before the first command word is taken; configuration writes are taken at
// any time but must only be made while the block is idle.
module text_console_char_writer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcw_in_if.sink                         i_in,
    tcw_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [tcw_pkg::COL_W-1:0]  r_width;
    logic [tcw_pkg::ROW_W-1:0]  r_height;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    tcw_pkg::t_cfg              cfg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tcw_pkg::WIDTH_RESET;
            r_height <= tcw_pkg::HEIGHT_RESET;
            r_attr   <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcw_pkg::REG_WIDTH:  r_width  <= tcw_pkg::COL_W'(i_cfg_data);
                tcw_pkg::REG_HEIGHT: r_height <= tcw_pkg::ROW_W'(i_cfg_data);
                tcw_pkg::REG_ATTR:   r_attr   <= tcw_pkg::ATTR_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            cfg.cols = tcw_pkg::COL_W'(1);
        end else if (32'(r_width) > MAX_COLS) begin
            cfg.cols = tcw_pkg::COL_W'(MAX_COLS);
        end else begin
            cfg.cols = r_width;
        end
        if (r_height == '0) begin
            cfg.rows = tcw_pkg::ROW_W'(1);
        end else if (32'(r_height) > MAX_ROWS) begin
            cfg.rows = tcw_pkg::ROW_W'(MAX_ROWS);
        end else begin
            cfg.rows = r_height;
        end
        cfg.attr = r_attr;
    end

    tcw_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: rtl/tcw_checker.sv
// Port-level checks of the text console writer and their bind to the top level.
// Depends on text_console_char_writer_defines.svh for the assertion macros.
`include "text_console_char_writer_defines.svh"

module tcw_checker #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tcw_pkg::COL_W-1:0]    i_cursor_col,
    input logic [tcw_pkg::ROW_W-1:0]    i_cursor_row
);

    // A command word is worked on alone: no second word right after one is taken.
    `TCW_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A result word appears only after the sequencer has left its idle state.
    `TCW_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

    // A stalled result word holds its cursor.
    `TCW_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_cursor_col) && $stable(i_cursor_row))

    // The cursor stays within the largest screen or just past its last column or row.
    `TCW_ASSERT_NOW(a_cursor_bounds, i_clk, i_rst_n, i_out_valid,
        32'(i_cursor_col) <= MAX_COLS && 32'(i_cursor_row) <= MAX_ROWS)

endmodule

bind text_console_char_writer tcw_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cursor_col (o_out.cursor_col),
    .i_cursor_row (o_out.cursor_row)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console character writer: a shadow screen and
// cursor predict each result word. Depends on tcw_pkg, tcw_in_if, tcw_out_if and the RTL.
module tb_top;

    localparam int SCREEN_MAX_COLS = 128;
    localparam int SCREEN_MAX_ROWS = 32;
    localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [tcw_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [tcw_pkg::CELL_W-1:0] cell_val;
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::ROW_W-1:0]  row;
    } t_console_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [tcw_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data;

    tcw_in_if  cmd_if ();
    tcw_out_if res_if ();

    logic [tcw_pkg::CELL_W-1:0] shadow_cells [SCREEN_MAX_COLS*SCREEN_MAX_ROWS];
    int unsigned shadow_col;
    int unsigned shadow_row;
    logic [tcw_pkg::COL_W-1:0] shadow_width;
    logic [tcw_pkg::ROW_W-1:0] shadow_height;
    logic [tcw_pkg::ATTR_W-1:0] shadow_attr;

    t_console_report pending_reports [$];
    int unsigned mismatch_count = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned res_stall_left = 0;

    text_console_char_writer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned active_cols();
        if (shadow_width == 0) return 1;
        if (shadow_width > SCREEN_MAX_COLS) return SCREEN_MAX_COLS;
        return shadow_width;
    endfunction

    function automatic int unsigned active_rows();
        if (shadow_height == 0) return 1;
        if (shadow_height > SCREEN_MAX_ROWS) return SCREEN_MAX_ROWS;
        return shadow_height;
    endfunction

    function automatic void scroll_shadow_up(int unsigned w, int unsigned h);
        int unsigned keep;
        keep = w * (h - 1);
        for (int unsigned i = 0; i < keep; i++) begin
            shadow_cells[i] = shadow_cells[i + w];
        end
        for (int unsigned i = keep; i < keep + w; i++) begin
            shadow_cells[i] = '0;
        end
    endfunction

    function automatic void put_shadow_char(logic [tcw_pkg::CHAR_W-1:0] ch);
        int unsigned w;
        int unsigned h;
        logic [tcw_pkg::CELL_W-1:0] attr_hi;
        w = active_cols();
        h = active_rows();
        attr_hi = {shadow_attr, 8'h00};
        if (ch == tcw_pkg::CH_NUL) return;
        if (shadow_col >= w) begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= h) begin
            scroll_shadow_up(w, h);
            shadow_row = h - 1;
        end
        case (ch)
            tcw_pkg::CH_LF: begin
                shadow_row++;
                shadow_col = 0;
            end
            tcw_pkg::CH_CR: shadow_col = 0;
            tcw_pkg::CH_BS: begin
                if (shadow_col > 0) shadow_col--;
                shadow_cells[shadow_row * w + shadow_col] = attr_hi;
            end
            default: begin
                shadow_cells[shadow_row * w + shadow_col] = attr_hi | ch;
                shadow_col++;
            end
        endcase
    endfunction

    function automatic t_console_report predict_console_word(
        logic [tcw_pkg::CMD_W-1:0] cmd, logic [tcw_pkg::CHAR_W-1:0] ch,
        logic [tcw_pkg::RROW_W-1:0] rrow, logic [tcw_pkg::RCOL_W-1:0] rcol);
        t_console_report rep;
        int unsigned w;
        int unsigned h;
        rep.cell_val = '0;
        w = active_cols();
        h = active_rows();
        case (cmd)
            tcw_pkg::CMD_PUT: put_shadow_char(ch);
            tcw_pkg::CMD_READ: begin
                if (rrow < h && rcol < w) rep.cell_val = shadow_cells[rrow * w + rcol];
            end
            tcw_pkg::CMD_CLEAR: begin
                for (int unsigned i = 0; i < w * h; i++) shadow_cells[i] = '0;
            end
            default: ;
        endcase
        rep.col = shadow_col[tcw_pkg::COL_W-1:0];
        rep.row = shadow_row[tcw_pkg::ROW_W-1:0];
        return rep;
    endfunction

    function automatic int unsigned pick_idle_length(int unsigned pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_console_word(input logic [tcw_pkg::CMD_W-1:0] cmd,
                                     input logic [tcw_pkg::CHAR_W-1:0] ch,
                                     input logic [tcw_pkg::RROW_W-1:0] rrow,
                                     input logic [tcw_pkg::RCOL_W-1:0] rcol);
        int unsigned gap;
        gap = pick_idle_length(gap_pct);
        if (gap != 0) begin
            @(negedge i_clk);
            cmd_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.valid     = 1'b1;
        cmd_if.command   = cmd;
        cmd_if.char_code = ch;
        cmd_if.read_row  = rrow;
        cmd_if.read_col  = rcol;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_reports.push_back(predict_console_word(cmd, ch, rrow, rcol));
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle_block();
        hold_until_drained();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_console_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [tcw_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            tcw_pkg::REG_WIDTH:  shadow_width  = data;
            tcw_pkg::REG_HEIGHT: shadow_height = data[tcw_pkg::ROW_W-1:0];
            tcw_pkg::REG_ATTR:   shadow_attr   = data;
            default: ;
        endcase
    endtask

    task automatic test_directed_basics();
        gap_pct   = 30;
        stall_pct = 30;
        send_console_word(tcw_pkg::CMD_PUT, 8'h41, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, 8'hFF, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, 8'h80, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_NUL, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, 8'h01, '0, '0);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd2);
        send_console_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, '0, '0);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
        send_console_word(tcw_pkg::CMD_PUT, 8'h7E, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, '0, '0);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
        send_console_word(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
        send_console_word(tcw_pkg::CMD_READ, 8'hFF, 5'd31, 7'd127);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'd79);
        send_console_word(tcw_pkg::CMD_CLEAR, 8'h00, '0, '0);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    endtask

    // The cursor left past a one-cell screen must wrap and scroll before the write.
    task automatic test_tiny_screen();
        settle_block();
        write_console_reg(tcw_pkg::REG_WIDTH, 8'd1);
        write_console_reg(tcw_pkg::REG_HEIGHT, 8'd1);
        write_console_reg(tcw_pkg::REG_ATTR, 8'hA5);
        send_console_word(tcw_pkg::CMD_PUT, 8'h42, '0, '0);
        send_console_word(tcw_pkg::CMD_PUT, 8'h43, '0, '0);
        send_console_word(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    endtask

    task automatic run_text_phase(input logic [7:0] cols, input logic [7:0] rows,
                                  input logic [7:0] attr, input int unsigned words,
                                  input int unsigned idle_pct);
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        logic [tcw_pkg::CMD_W-1:0] cmd;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        logic [tcw_pkg::RROW_W-1:0] rrow;
        logic [tcw_pkg::RCOL_W-1:0] rcol;
        settle_block();
        write_console_reg(tcw_pkg::REG_WIDTH, cols);
        write_console_reg(tcw_pkg::REG_HEIGHT, rows);
        write_console_reg(tcw_pkg::REG_ATTR, attr);
        if ($urandom_range(1) == 1) write_console_reg(REG_NONE, 8'($urandom_range(255)));
        gap_pct   = idle_pct;
        stall_pct = idle_pct;
        w = active_cols();
        h = active_rows();
        for (int unsigned k = 0; k < words; k++) begin
            if (k == words / 2) hold_until_drained();
            pick = $urandom_range(99);
            ch   = 8'($urandom_range(255));
            rrow = 5'($urandom_range(31));
            rcol = 7'($urandom_range(127));
            if (pick < 60) begin
                cmd  = tcw_pkg::CMD_PUT;
                pick = $urandom_range(99);
                if (pick < 8) ch = tcw_pkg::CH_LF;
                else if (pick < 13) ch = tcw_pkg::CH_CR;
                else if (pick < 20) ch = tcw_pkg::CH_BS;
                else if (pick < 24) ch = tcw_pkg::CH_NUL;
            end else if (pick < 93) begin
                cmd = tcw_pkg::CMD_READ;
                if ($urandom_range(4) != 0) begin
                    rcol = 7'($urandom_range(w - 1));
                    if ($urandom_range(1) == 1)
                        rrow = 5'((shadow_row < h) ? shadow_row : h - 1);
                    else
                        rrow = 5'($urandom_range(h - 1));
                end
            end else if (pick < 97) begin
                cmd = tcw_pkg::CMD_CLEAR;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_console_word(cmd, ch, rrow, rcol);
        end
    endtask

    task automatic test_random_phases();
        int unsigned phase_cols [12] = '{1, 0, 255, 128, 3, 16, 40, 5, 80, 2, 129, 7};
        int unsigned phase_rows [12] = '{1, 0, 63, 32, 2, 4, 10, 1, 25, 33, 3, 6};
        int unsigned phase_idle [12] = '{30, 0, 30, 50, 20, 30, 0, 30, 20, 60, 30, 10};
        logic [7:0] attr;
        for (int p = 0; p < 12; p++) begin
            if (p == 0) attr = 8'h00;
            else if (p == 1) attr = 8'hFF;
            else attr = 8'($urandom_range(255));
            run_text_phase(8'(phase_cols[p]), 8'(phase_rows[p]), attr, 119, phase_idle[p]);
        end
    endtask

    task automatic finish_run();
        hold_until_drained();
        repeat (20) @(posedge i_clk);
        if (pending_reports.size() != 0)
            report_mismatch("result words never arrived", 0, pending_reports.size());
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    endtask

    always @(negedge i_clk) begin
        if (res_stall_left != 0) begin
            res_if.ready = 1'b0;
            res_stall_left--;
        end else begin
            res_if.ready   = 1'b1;
            res_stall_left = pick_idle_length(stall_pct);
        end
    end

    initial begin : result_checker
        t_console_report got;
        t_console_report want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.cell_val = res_if.cell_value;
                got.col      = res_if.cursor_col;
                got.row      = res_if.cursor_row;
                @(negedge i_clk);
                if (pending_reports.size() == 0) begin
                    report_mismatch("result word with nothing pending", got.cell_val, 0);
                end else begin
                    want = pending_reports.pop_front();
                    if (got.cell_val !== want.cell_val)
                        report_mismatch("cell_value", got.cell_val, want.cell_val);
                    if (got.col !== want.col) report_mismatch("cursor_col", got.col, want.col);
                    if (got.row !== want.row) report_mismatch("cursor_row", got.row, want.row);
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = tcw_pkg::REG_WIDTH;
        cfg_data         = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.command   = tcw_pkg::CMD_PUT;
        cmd_if.char_code = tcw_pkg::CH_NUL;
        cmd_if.read_row  = '0;
        cmd_if.read_col  = '0;
        res_if.ready     = 1'b0;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        shadow_col    = 0;
        shadow_row    = 0;
        shadow_width  = tcw_pkg::WIDTH_RESET;
        shadow_height = tcw_pkg::HEIGHT_RESET;
        shadow_attr   = tcw_pkg::ATTR_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_basics();
        test_tiny_screen();
        test_random_phases();
        finish_run();
    end
endmodule
